// File: hdl/i2c3w_pkg.sv
// shared constants and types for the three-byte i2c write master
`timescale 1ns / 1ps
`default_nettype none

package i2c3w_pkg;

  // reset value of the address byte: 7-bit target 0x3c with write bit
  localparam logic [7:0] ADDR_RESET = 8'h78;

  // control bytes sent as the second byte
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  // tick positions inside a transaction, 0 means idle
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_IDLE       = 6'd0;
  localparam logic [POS_W-1:0] POS_FIRST      = 6'd1;
  localparam logic [POS_W-1:0] POS_START_COND = 6'd2;
  localparam logic [POS_W-1:0] POS_BYTES      = 6'd3;
  localparam logic [POS_W-1:0] POS_STOP_LOW   = 6'd57;
  localparam logic [POS_W-1:0] POS_STOP_HIGH  = 6'd58;
  localparam logic [POS_W-1:0] POS_LAST       = 6'd59;

  // tick slot inside one byte: 16 bit ticks, then ack low and ack high
  localparam int unsigned SLOT_W = 5;
  localparam logic [SLOT_W-1:0] SLOT_FIRST    = 5'd0;
  localparam logic [SLOT_W-1:0] SLOT_ACK_LOW  = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_ACK_HIGH = 5'd17;

  // which byte is on the wire
  localparam logic [1:0] BYTE_ADDR = 2'd0;
  localparam logic [1:0] BYTE_CTRL = 2'd1;

  // line state and status for one tick
  typedef struct packed {
    logic scl;
    logic sda;
    logic busy_res;
    logic done_res;
    logic nack;
  } i2c3w_res_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic idle;
    logic last;
  } i2c3w_stat_t;

endpackage

`default_nettype wire

// File: hdl/i2c3w_if.sv
// valid/ready channel interfaces for tick items, results and configuration
`timescale 1ns / 1ps
`default_nettype none

interface i2c3w_req_if;
  logic       valid;
  logic       ready;
  logic       begin_req;
  logic       is_data;
  logic [7:0] payload;
  logic       sda_in;

  modport source (output valid, output begin_req, output is_data, output payload,
                  output sda_in, input ready);
  modport sink   (input valid, input begin_req, input is_data, input payload,
                  input sda_in, output ready);
endinterface

interface i2c3w_res_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  logic busy_res;
  logic done_res;
  logic nack;

  modport source (output valid, output scl, output sda, output busy_res,
                  output done_res, output nack, input ready);
  modport sink   (input valid, input scl, input sda, input busy_res,
                  input done_res, input nack, output ready);
endinterface

interface i2c3w_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/i2c3w_seq.sv
// transaction sequencer: tick position, byte shifter and line levels
`timescale 1ns / 1ps
`default_nettype none

module i2c3w_seq
  import i2c3w_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        begin_req,
  input  wire logic        is_data,
  input  wire logic [7:0]  payload,
  input  wire logic        sda_in,
  input  wire logic [7:0]  address_byte,
  output i2c3w_res_t       res,
  output i2c3w_stat_t      stat
);

  logic [POS_W-1:0]  pos;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        byte_index;
  logic [7:0]        shift_reg;
  logic              kind_latch;
  logic [7:0]        payload_latch;
  logic              nack_seen;

  logic [POS_W-1:0]  pos_eff;
  logic              starting;
  logic              in_bytes;
  logic [7:0]        byte_sel;
  logic [7:0]        cur_byte;

  // a request on an idle tick makes that tick the first of the transaction
  assign starting = (pos == POS_IDLE) && begin_req;
  assign pos_eff  = starting ? POS_FIRST : pos;
  assign in_bytes = (pos_eff >= POS_BYTES) && (pos_eff < POS_STOP_LOW);

  // byte to load at the start of each byte slot
  always_comb begin
    unique case (byte_index)
      BYTE_ADDR: byte_sel = address_byte;
      BYTE_CTRL: byte_sel = kind_latch ? CTRL_DATA : CTRL_CMD;
      default:   byte_sel = payload_latch;
    endcase
  end

  assign cur_byte = (slot == SLOT_FIRST) ? byte_sel : shift_reg;

  // line levels for this tick
  always_comb begin
    res = '{scl: 1'b1, sda: 1'b1, busy_res: 1'b0, done_res: 1'b0, nack: 1'b0};
    if (pos_eff != POS_IDLE) begin
      res.busy_res = 1'b1;
      priority if (pos_eff == POS_FIRST) begin
        res.sda = 1'b1;
      end else if (pos_eff == POS_START_COND) begin
        res.sda = 1'b0;
      end else if (in_bytes) begin
        if (slot < SLOT_ACK_LOW) begin
          res.scl = slot[0];
          res.sda = cur_byte[7];
        end else if (slot == SLOT_ACK_LOW) begin
          res.scl = 1'b0;
        end
      end else if (pos_eff == POS_STOP_LOW) begin
        res.scl = 1'b0;
        res.sda = 1'b0;
      end else if (pos_eff == POS_STOP_HIGH) begin
        res.sda = 1'b0;
      end else begin
        res.done_res = 1'b1;
        res.nack     = nack_seen;
      end
    end
  end

  assign stat.idle = (pos == POS_IDLE);
  assign stat.last = (pos == POS_LAST);

  // state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_IDLE;
      slot          <= SLOT_FIRST;
      byte_index    <= BYTE_ADDR;
      shift_reg     <= '0;
      kind_latch    <= 1'b0;
      payload_latch <= '0;
      nack_seen     <= 1'b0;
    end else if (step) begin
      if (starting) begin
        kind_latch    <= is_data;
        payload_latch <= payload;
        nack_seen     <= 1'b0;
      end
      if (pos_eff != POS_IDLE) begin
        pos <= (pos_eff == POS_LAST) ? POS_IDLE : pos_eff + POS_W'(1);
      end
      if (pos_eff == POS_START_COND) begin
        slot       <= SLOT_FIRST;
        byte_index <= BYTE_ADDR;
      end
      if (in_bytes) begin
        if (slot == SLOT_ACK_HIGH) begin
          slot       <= SLOT_FIRST;
          byte_index <= byte_index + 2'd1;
          if (sda_in) begin
            nack_seen <= 1'b1;
          end
        end else begin
          slot <= slot + SLOT_W'(1);
        end
        // shift after each clock-high bit tick
        if (slot < SLOT_ACK_LOW) begin
          shift_reg <= slot[0] ? {cur_byte[6:0], 1'b0} : cur_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/i2c3w_obuf.sv
// output register holding one result item until it is taken
`timescale 1ns / 1ps
`default_nettype none

module i2c3w_obuf
  import i2c3w_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire i2c3w_res_t res_in,
  output logic            space,
  i2c3w_res_if.source     res
);

  logic       valid;
  i2c3w_res_t data;

  // room for a new item when empty or when the held one leaves now
  assign space = !valid || res.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

  assign res.valid    = valid;
  assign res.scl      = data.scl;
  assign res.sda      = data.sda;
  assign res.busy_res = data.busy_res;
  assign res.done_res = data.done_res;
  assign res.nack     = data.nack;

endmodule

`default_nettype wire

// File: hdl/i2c_three_byte_write_master.sv
// top level of the three-byte i2c write master
//
//  channel  dir  payload                               accepted when
//  req      in   begin_req, is_data, payload, sda_in   req.valid & req.ready
//  res      out  scl, sda, busy_res, done_res, nack    res.valid & res.ready
//  cfg      in   data (address byte)                   cfg.valid & cfg.ready
//
// one tick item in, one line-state item out; one item per cycle sustained while results are taken
// each result is registered: sequencer logic feeds a single output register
// req.ready drops only while a held result is not taken; cfg is always ready
// a transaction is 59 ticks; synchronous reset returns to idle, address 0x78
`timescale 1ns / 1ps
`default_nettype none

module i2c_three_byte_write_master
  import i2c3w_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  i2c3w_req_if.sink   req,
  i2c3w_res_if.source res,
  i2c3w_cfg_if.sink   cfg
);

  logic        address_byte;
  logic [7:0]  addr_reg;
  logic        space;
  logic        step;
  i2c3w_res_t  seq_res;
  i2c3w_stat_t stat;

  // address register, written whenever a write is offered
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_reg <= ADDR_RESET;
    end else if (cfg.valid) begin
      addr_reg <= cfg.data;
    end
  end
  assign address_byte = addr_reg[7];

  assign req.ready = space;
  assign step      = req.valid && space;

  i2c3w_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .begin_req    (req.begin_req),
    .is_data      (req.is_data),
    .payload      (req.payload),
    .sda_in       (req.sda_in),
    .address_byte (addr_reg),
    .res          (seq_res),
    .stat         (stat)
  );

  i2c3w_obuf u_obuf (
    .clk    (clk),
    .rst    (rst),
    .load   (step),
    .res_in (seq_res),
    .space  (space),
    .res    (res)
  );

  // an accepted item always yields a held result next cycle
  a_item_yields_result: assert property (@(posedge clk) disable iff (rst)
    step |=> res.valid)
    else $error("accepted item did not produce a result");

  // an idle tick without a request stays idle
  a_idle_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (step && stat.idle && !req.begin_req) |=> (!res.busy_res && stat.idle))
    else $error("idle tick started a transaction");

  // the last tick ends the transaction with done
  a_last_tick_done: assert property (@(posedge clk) disable iff (rst)
    (step && stat.last) |=> (res.done_res && stat.idle))
    else $error("last tick did not end the transaction");

  // nack is only ever reported together with done
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    (step && !stat.last) |=> !res.nack)
    else $error("nack outside the done tick");

  // high address bit mirrors the register that feeds the first byte
  a_addr_tracks_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |=> (address_byte == $past(cfg.data[7])))
    else $error("address register missed a write");

endmodule

`default_nettype wire

// File: test/i2c_three_byte_write_master_checker.sv
// line-state predictor and result checker for the three-byte i2c write master
`timescale 1ns / 1ps

module i2c_three_byte_write_master_checker
  import i2c3w_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  i2c3w_req_if      req,
  i2c3w_res_if      res,
  i2c3w_cfg_if      cfg,
  output int        fail_count,
  output int        pending
);

  localparam int TICKS_PER_BYTE = 18;

  // shadow of the sequencer state
  logic [7:0] addr_reg;
  logic [6:0] step;
  logic [7:0] shreg;
  logic       kind;
  logic [7:0] pay;
  logic       nack_seen;

  i2c3w_res_t line_q[$];
  i2c3w_res_t want;
  i2c3w_res_t got;
  int         bad;
  string      field_names[5] = '{"scl", "sda", "busy_res", "done_res", "nack"};

  // advance the shadow sequencer by one tick and return its line state
  function automatic i2c3w_res_t next_line(input logic b, input logic k,
                                           input logic [7:0] p, input logic s);
    i2c3w_res_t r;
    int         pos;
    int         t;
    int         w;
    r = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
    pos = int'(step);
    // a request only counts on an idle tick, and that tick is the first one
    if (pos == int'(POS_IDLE) && b) begin
      kind = k;
      pay = p;
      nack_seen = 1'b0;
      pos = int'(POS_FIRST);
    end
    if (pos != int'(POS_IDLE)) begin
      r.busy_res = 1'b1;
      if (pos == int'(POS_FIRST)) begin
        r.sda = 1'b1;
      end else if (pos == int'(POS_START_COND)) begin
        r.sda = 1'b0;
      end else if (pos < int'(POS_STOP_LOW)) begin
        t = pos - int'(POS_BYTES);
        w = t % TICKS_PER_BYTE;
        // the byte is picked when its first tick comes, so late address writes count
        if (w == int'(SLOT_FIRST)) begin
          case (2'(t / TICKS_PER_BYTE))
            BYTE_ADDR: shreg = addr_reg;
            BYTE_CTRL: shreg = kind ? CTRL_DATA : CTRL_CMD;
            default:   shreg = pay;
          endcase
        end
        if (w < int'(SLOT_ACK_LOW)) begin
          r.sda = shreg[7];
          r.scl = w[0];
          if (w[0]) shreg = {shreg[6:0], 1'b0};
        end else if (w == int'(SLOT_ACK_LOW)) begin
          r.scl = 1'b0;
        end else if (s) begin
          nack_seen = 1'b1;
        end
      end else if (pos == int'(POS_STOP_LOW)) begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end else if (pos == int'(POS_STOP_HIGH)) begin
        r.sda = 1'b0;
      end else begin
        r.done_res = 1'b1;
        r.nack = nack_seen;
      end
      step = (pos >= int'(POS_LAST)) ? 7'(POS_IDLE) : 7'(pos + 1);
    end
    return r;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    bad = 0;
    if (rst) begin
      addr_reg = ADDR_RESET;
      step = 7'(POS_IDLE);
      shreg = 8'h00;
      kind = 1'b0;
      pay = 8'h00;
      nack_seen = 1'b0;
      line_q.delete();
      fail_count <= 0;
    end else begin
      // a result here belongs to an item taken at an earlier edge
      if (res.valid && res.ready) begin
        got = {res.scl, res.sda, res.busy_res, res.done_res, res.nack};
        if (line_q.size() == 0) begin
          bad++;
          $error("result item with no expectation waiting");
        end else begin
          want = line_q.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (want[4-i] !== got[4-i]) begin
              bad++;
              $error("%s: expected %0b, got %0b", field_names[i], want[4-i], got[4-i]);
            end
          end
        end
      end
      // an item taken at this edge still sees the old address
      if (req.valid && req.ready)
        line_q.push_back(next_line(req.begin_req, req.is_data, req.payload, req.sda_in));
      if (cfg.valid && cfg.ready) addr_reg = cfg.data;
      fail_count <= fail_count + bad;
    end
    pending <= line_q.size();
  end

endmodule

// File: test/i2c_three_byte_write_master_tb.sv
// stimulus, handshake pacing and verdict for the three-byte i2c write master
`timescale 1ns / 1ps

module i2c_three_byte_write_master_tb;
  import i2c3w_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 333;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst;
  int   gap_pct;
  int   stall_pct;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   hold_left;
  logic squeeze_on;
  logic squeeze_taken;

  i2c3w_req_if req_ch ();
  i2c3w_res_if res_ch ();
  i2c3w_cfg_if cfg_ch ();

  i2c_three_byte_write_master dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  i2c_three_byte_write_master_checker line_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold so the block backs up
  initial begin
    res_ch.ready = 1'b0;
    hold_left = 0;
    squeeze_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_on && !squeeze_taken) begin
        squeeze_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one tick item, with random idle cycles first, and wait until taken
  task automatic send_tick(input logic b, input logic k, input logic [7:0] p,
                           input logic s);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.begin_req <= b;
    req_ch.is_data <= k;
    req_ch.payload <= p;
    req_ch.sda_in <= s;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // wait until every expected line state has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_addr(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.begin_req = 1'b0;
    req_ch.is_data = 1'b0;
    req_ch.payload = 8'h00;
    req_ch.sda_in = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'h00;
    gap_pct = 0;
    stall_pct = 0;
    squeeze_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // idle tick ignores kind, payload and sda_in
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
    // request on an idle tick: data kind, all-ones payload
    send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
    wait_drained();
    // address write inside the transaction, before the address byte begins
    write_addr(8'h00);
    // requests while busy are ignored; sda_in high forces a nack on the address
    for (int i = 0; i < 20; i++) send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    wait_drained();

    // random phases with different pacing and address settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_addr(8'hFF);
        1: write_addr(8'(ADDR_RESET));
        default: write_addr(8'($urandom_range(255)));
      endcase
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  squeeze_on = 1'b1; end
        1: begin gap_pct = 51; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 51; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_tick($urandom_range(99) < 30, 1'($urandom_range(1)),
                  8'($urandom_range(255)), $urandom_range(99) < 8);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: i2c_three_byte_write_master.f
hdl/i2c3w_pkg.sv
hdl/i2c3w_if.sv
hdl/i2c3w_seq.sv
hdl/i2c3w_obuf.sv
hdl/i2c_three_byte_write_master.sv
test/i2c_three_byte_write_master_checker.sv
test/i2c_three_byte_write_master_tb.sv
